@@ rtl/core/qpr_pkg.sv @@
// Shared widths, constants and operand kinds for the quaternion product/rotate unit.
`default_nettype none

package qpr_pkg;

  // Q3.12 operand format.
  localparam int DATA_W = 16;
  localparam int FRAC_W = 12;
  localparam int NCOMP  = 4;

  // Final rounding is always done at twice the fraction width.
  localparam int ROT_SHIFT = 2 * FRAC_W;

  // First Hamilton sum: four 16x16 products, two guard bits.
  localparam int T_W  = 2 * DATA_W + 2;
  // Conjugate of A needs one extra bit (negating -32768).
  localparam int QC_W = DATA_W + 1;
  // Second products and their sum.
  localparam int PR_W = T_W + QC_W;
  localparam int R_W  = PR_W + 2;

  // Unit scalar in Q3.12, used to lift a product result to the rotation scale.
  localparam logic signed [QC_W-1:0] ONE_Q = QC_W'(1 << FRAC_W);

  typedef enum logic {
    KIND_PRODUCT = 1'b0,
    KIND_ROTATE  = 1'b1
  } kind_t;

endpackage

`default_nettype wire

@@ rtl/core/qpr_mul.sv @@
// Registered 4x4 grid of component products p[i]*q[j] for one Hamilton product.
`default_nettype none

module qpr_mul #(
  parameter int P_W = qpr_pkg::DATA_W,
  parameter int Q_W = qpr_pkg::DATA_W
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [P_W-1:0]    p      [qpr_pkg::NCOMP],
  input  logic signed [Q_W-1:0]    q      [qpr_pkg::NCOMP],
  output logic signed [P_W+Q_W-1:0] prod_r [qpr_pkg::NCOMP][qpr_pkg::NCOMP]
);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < qpr_pkg::NCOMP; i++) begin
        for (int j = 0; j < qpr_pkg::NCOMP; j++) begin
          prod_r[i][j] <= p[i] * q[j];
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/qpr_add.sv @@
// Registered signed sums that combine a product grid into a Hamilton product.
`default_nettype none

module qpr_add #(
  parameter int M_W = 2 * qpr_pkg::DATA_W
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [M_W-1:0] prod  [qpr_pkg::NCOMP][qpr_pkg::NCOMP],
  output logic signed [M_W+1:0] sum_r [qpr_pkg::NCOMP]
);

  localparam int S_W = M_W + 2;

  logic signed [S_W-1:0] sum_nxt [qpr_pkg::NCOMP];

  // o = p*q with components ordered w, x, y, z
  always_comb begin
    sum_nxt[0] = S_W'(prod[0][0]) - S_W'(prod[1][1]) - S_W'(prod[2][2]) - S_W'(prod[3][3]);
    sum_nxt[1] = S_W'(prod[0][1]) + S_W'(prod[1][0]) + S_W'(prod[2][3]) - S_W'(prod[3][2]);
    sum_nxt[2] = S_W'(prod[0][2]) - S_W'(prod[1][3]) + S_W'(prod[2][0]) + S_W'(prod[3][1]);
    sum_nxt[3] = S_W'(prod[0][3]) + S_W'(prod[1][2]) - S_W'(prod[2][1]) + S_W'(prod[3][0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < qpr_pkg::NCOMP; i++) begin
        sum_r[i] <= sum_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/qpr_round.sv @@
// Output stage: round to nearest, saturate to Q3.12, zero w for rotations.
`default_nettype none

module qpr_round (
  input  logic                                clk,
  input  logic                                en,
  input  qpr_pkg::kind_t                      kind,
  input  logic signed [qpr_pkg::R_W-1:0]      sum [qpr_pkg::NCOMP],
  output logic signed [qpr_pkg::DATA_W-1:0]   r_r [qpr_pkg::NCOMP]
);

  localparam int SH_W = qpr_pkg::R_W - qpr_pkg::ROT_SHIFT;
  localparam logic signed [SH_W-1:0] SAT_MAX = SH_W'((1 << (qpr_pkg::DATA_W - 1)) - 1);
  localparam logic signed [SH_W-1:0] SAT_MIN = -SH_W'(1 << (qpr_pkg::DATA_W - 1));
  localparam logic signed [qpr_pkg::R_W-1:0] HALF = qpr_pkg::R_W'(1) <<< (qpr_pkg::ROT_SHIFT - 1);

  logic signed [qpr_pkg::R_W-1:0]    biased [qpr_pkg::NCOMP];
  logic signed [SH_W-1:0]            shd    [qpr_pkg::NCOMP];
  logic signed [qpr_pkg::DATA_W-1:0] r_nxt  [qpr_pkg::NCOMP];

  always_comb begin
    for (int i = 0; i < qpr_pkg::NCOMP; i++) begin
      biased[i] = sum[i] + HALF;
      shd[i]    = SH_W'(biased[i] >>> qpr_pkg::ROT_SHIFT);
      if (shd[i] > SAT_MAX) begin
        r_nxt[i] = qpr_pkg::DATA_W'(SAT_MAX);
      end else if (shd[i] < SAT_MIN) begin
        r_nxt[i] = qpr_pkg::DATA_W'(SAT_MIN);
      end else begin
        r_nxt[i] = qpr_pkg::DATA_W'(shd[i]);
      end
    end
    // Rotations carry no scalar part.
    if (kind == qpr_pkg::KIND_ROTATE) begin
      r_nxt[0] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < qpr_pkg::NCOMP; i++) begin
        r_r[i] <= r_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/quaternion_product_and_rotate_unit.sv @@
// Throughput: one item per cycle while the output is not stalled; each of the five stages
// advances on its own when the stage after it is empty or moving, so bubbles collapse and a
// waiting result blocks input only once all five stages hold an item.
// Reset (rst_n low, synchronous) clears the stage valid bits only; data registers are not reset.
// Stages: A*B products, Hamilton sums, products with conj(A) or unity, sums, round and saturate.
`default_nettype none

module quaternion_product_and_rotate_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic signed [qpr_pkg::DATA_W-1:0] in_a_w,
  input  logic signed [qpr_pkg::DATA_W-1:0] in_a_x,
  input  logic signed [qpr_pkg::DATA_W-1:0] in_a_y,
  input  logic signed [qpr_pkg::DATA_W-1:0] in_a_z,
  input  logic signed [qpr_pkg::DATA_W-1:0] in_b_w,
  input  logic signed [qpr_pkg::DATA_W-1:0] in_b_x,
  input  logic signed [qpr_pkg::DATA_W-1:0] in_b_y,
  input  logic signed [qpr_pkg::DATA_W-1:0] in_b_z,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [qpr_pkg::DATA_W-1:0] out_r_w,
  output logic signed [qpr_pkg::DATA_W-1:0] out_r_x,
  output logic signed [qpr_pkg::DATA_W-1:0] out_r_y,
  output logic signed [qpr_pkg::DATA_W-1:0] out_r_z
);

  localparam int NSTG = 5;

  // ---------------------------------------------------------------------------
  // Stage control: valid bit per stage, ready ripples back from the output.
  // ---------------------------------------------------------------------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] rdy;
  logic [NSTG-1:0] en;

  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  // Load a stage when it can take a transfer and the stage before it holds one.
  always_comb begin
    en[0]      = rdy[0] && in_valid;
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      en[k]      = rdy[k] && vld_r[k-1];
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NSTG-1];

  // ---------------------------------------------------------------------------
  // Side data that travels with each item: kind through all stages, A up to
  // the second multiply.
  // ---------------------------------------------------------------------------
  qpr_pkg::kind_t in_kind_e;
  qpr_pkg::kind_t kind1_r, kind2_r, kind3_r, kind4_r;
  logic signed [qpr_pkg::DATA_W-1:0] a_in [qpr_pkg::NCOMP];
  logic signed [qpr_pkg::DATA_W-1:0] b_in [qpr_pkg::NCOMP];
  logic signed [qpr_pkg::DATA_W-1:0] a1_r [qpr_pkg::NCOMP];
  logic signed [qpr_pkg::DATA_W-1:0] a2_r [qpr_pkg::NCOMP];

  assign in_kind_e = qpr_pkg::kind_t'(in_kind);

  always_comb begin
    a_in[0] = in_a_w;
    a_in[1] = in_a_x;
    a_in[2] = in_a_y;
    a_in[3] = in_a_z;
    // A rotation works on the pure quaternion (0, v): drop b_w.
    b_in[0] = (in_kind_e == qpr_pkg::KIND_ROTATE) ? '0 : in_b_w;
    b_in[1] = in_b_x;
    b_in[2] = in_b_y;
    b_in[3] = in_b_z;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      kind1_r <= in_kind_e;
      a1_r    <= a_in;
    end
    if (en[1]) begin
      kind2_r <= kind1_r;
      a2_r    <= a1_r;
    end
    if (en[2]) begin
      kind3_r <= kind2_r;
    end
    if (en[3]) begin
      kind4_r <= kind3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 1-2: t = A * B, exact (Q.24).
  // ---------------------------------------------------------------------------
  logic signed [2*qpr_pkg::DATA_W-1:0] prod1 [qpr_pkg::NCOMP][qpr_pkg::NCOMP];
  logic signed [qpr_pkg::T_W-1:0]      t2    [qpr_pkg::NCOMP];

  qpr_mul #(
    .P_W(qpr_pkg::DATA_W),
    .Q_W(qpr_pkg::DATA_W)
  ) u_mul_ab (
    .clk   (clk),
    .en    (en[0]),
    .p     (a_in),
    .q     (b_in),
    .prod_r(prod1)
  );

  qpr_add #(
    .M_W(2 * qpr_pkg::DATA_W)
  ) u_add_ab (
    .clk  (clk),
    .en   (en[1]),
    .prod (prod1),
    .sum_r(t2)
  );

  // ---------------------------------------------------------------------------
  // Stages 3-4: r = t * q2, exact (Q.36). For a rotation q2 = conj(A); for a
  // plain product q2 = (1, 0, 0, 0) in Q3.12, which lifts t to the same
  // scale so one rounding step serves both kinds.
  // ---------------------------------------------------------------------------
  logic signed [qpr_pkg::QC_W-1:0] q2   [qpr_pkg::NCOMP];
  logic signed [qpr_pkg::PR_W-1:0] prod3 [qpr_pkg::NCOMP][qpr_pkg::NCOMP];
  logic signed [qpr_pkg::R_W-1:0]  r4   [qpr_pkg::NCOMP];

  always_comb begin
    if (kind2_r == qpr_pkg::KIND_ROTATE) begin
      q2[0] = qpr_pkg::QC_W'(a2_r[0]);
      for (int i = 1; i < qpr_pkg::NCOMP; i++) begin
        q2[i] = -qpr_pkg::QC_W'(a2_r[i]);
      end
    end else begin
      q2[0] = qpr_pkg::ONE_Q;
      for (int i = 1; i < qpr_pkg::NCOMP; i++) begin
        q2[i] = '0;
      end
    end
  end

  qpr_mul #(
    .P_W(qpr_pkg::T_W),
    .Q_W(qpr_pkg::QC_W)
  ) u_mul_tc (
    .clk   (clk),
    .en    (en[2]),
    .p     (t2),
    .q     (q2),
    .prod_r(prod3)
  );

  qpr_add #(
    .M_W(qpr_pkg::PR_W)
  ) u_add_tc (
    .clk  (clk),
    .en   (en[3]),
    .prod (prod3),
    .sum_r(r4)
  );

  // ---------------------------------------------------------------------------
  // Stage 5: round, saturate, hold the result until the output transfer.
  // ---------------------------------------------------------------------------
  logic signed [qpr_pkg::DATA_W-1:0] r5 [qpr_pkg::NCOMP];

  qpr_round u_round (
    .clk (clk),
    .en  (en[4]),
    .kind(kind4_r),
    .sum (r4),
    .r_r (r5)
  );

  assign out_r_w = r5[0];
  assign out_r_x = r5[1];
  assign out_r_y = r5[2];
  assign out_r_z = r5[3];

`ifndef SYNTHESIS
  // Items in flight change only by what enters and what leaves.
  a_item_count : assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ($countones(vld_r) == $past($countones(vld_r))
              + ($past(in_valid && in_ready) ? 1 : 0)
              - ($past(out_valid && out_ready) ? 1 : 0)))
    else $error("pipeline occupancy does not match transfers");

  // An empty first stage always takes input.
  a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[0] |-> in_ready)
    else $error("input stalled with empty first stage");

  // A rotation loaded into the output stage shows a zero scalar part.
  a_rot_w_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (en[4] && kind4_r == qpr_pkg::KIND_ROTATE) |=> (out_r_w == '0))
    else $error("rotation result has nonzero w");
`endif

endmodule

`default_nettype wire

@@ sim/tb_quaternion_product_and_rotate_unit.sv @@
// Self-checking testbench for the quaternion product and vector rotate unit.
`default_nettype none

module tb_quaternion_product_and_rotate_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import qpr_pkg::*;

  // Run control.
  localparam int RAND_PER_PHASE = 430;
  localparam int HOLDOFF_CYCLES = 200;
  localparam int DRAIN_CYCLES   = 20;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int MAX_REPORTS    = 10;

  typedef logic signed [DATA_W-1:0] comp_t;

  // One operation as it crosses the input channel.
  typedef struct packed {
    kind_t kind;
    comp_t a_w;
    comp_t a_x;
    comp_t a_y;
    comp_t a_z;
    comp_t b_w;
    comp_t b_x;
    comp_t b_y;
    comp_t b_z;
  } quat_op_t;

  // One result quaternion.
  typedef struct packed {
    comp_t w;
    comp_t x;
    comp_t y;
    comp_t z;
  } quat_res_t;

  // Exact intermediate quaternion, wide enough for the Q.36 rotation sums.
  typedef struct packed {
    longint w;
    longint x;
    longint y;
    longint z;
  } wide_quat_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;

  logic  in_valid = 1'b0;
  logic  in_ready;
  logic  in_kind = 1'b0;
  comp_t in_a_w = '0;
  comp_t in_a_x = '0;
  comp_t in_a_y = '0;
  comp_t in_a_z = '0;
  comp_t in_b_w = '0;
  comp_t in_b_x = '0;
  comp_t in_b_y = '0;
  comp_t in_b_z = '0;

  logic  out_valid;
  logic  out_ready = 1'b0;
  comp_t out_r_w;
  comp_t out_r_x;
  comp_t out_r_y;
  comp_t out_r_z;

  quaternion_product_and_rotate_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_kind  (in_kind),
    .in_a_w   (in_a_w),
    .in_a_x   (in_a_x),
    .in_a_y   (in_a_y),
    .in_a_z   (in_a_z),
    .in_b_w   (in_b_w),
    .in_b_x   (in_b_x),
    .in_b_y   (in_b_y),
    .in_b_z   (in_b_z),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_r_w  (out_r_w),
    .out_r_x  (out_r_x),
    .out_r_y  (out_r_y),
    .out_r_z  (out_r_z)
  );

  // 10 ns clock; falling edge drives, rising edge samples.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quat_op_t  quat_pend[$];    // operations waiting to be offered
  quat_res_t quat_expect[$];  // predicted results, oldest first

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic in_xfer = 1'b0;       // input transfer seen at the last rising edge
  int   bad_count = 0;
  int   result_count = 0;
  int   cycle_count = 0;

  // Long receiver hold-off, timed in its own process.
  logic holdoff_go = 1'b0;
  logic holdoff_done = 1'b0;
  int   holdoff_cnt = 0;
  wire  holdoff_active = holdoff_go && !holdoff_done;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic wide_quat_t hamilton(wide_quat_t p, wide_quat_t q);
    wide_quat_t o;
    o.w = p.w * q.w - p.x * q.x - p.y * q.y - p.z * q.z;
    o.x = p.w * q.x + p.x * q.w + p.y * q.z - p.z * q.y;
    o.y = p.w * q.y - p.x * q.z + p.y * q.w + p.z * q.x;
    o.z = p.w * q.z + p.x * q.y - p.y * q.x + p.z * q.w;
    return o;
  endfunction

  // Round half up at the given fraction width, then clamp to 16 bits.
  function automatic comp_t round_clamp(longint v, int sh);
    longint r;
    r = (v + (longint'(1) << (sh - 1))) >>> sh;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return comp_t'(r);
  endfunction

  function automatic quat_res_t quat_eval(quat_op_t op);
    wide_quat_t a;
    wide_quat_t b;
    wide_quat_t a_conj;
    wide_quat_t t;
    wide_quat_t r;
    quat_res_t  res;
    a.w = longint'(op.a_w);
    a.x = longint'(op.a_x);
    a.y = longint'(op.a_y);
    a.z = longint'(op.a_z);
    b.w = longint'(op.b_w);
    b.x = longint'(op.b_x);
    b.y = longint'(op.b_y);
    b.z = longint'(op.b_z);
    if (op.kind == KIND_PRODUCT) begin
      r = hamilton(a, b);
      res.w = round_clamp(r.w, FRAC_W);
      res.x = round_clamp(r.x, FRAC_W);
      res.y = round_clamp(r.y, FRAC_W);
      res.z = round_clamp(r.z, FRAC_W);
    end else begin
      // Drop b_w: the vector is a pure quaternion. Keep everything exact and
      // round once at the end.
      b.w = 0;
      a_conj.w = a.w;
      a_conj.x = -a.x;
      a_conj.y = -a.y;
      a_conj.z = -a.z;
      t = hamilton(a, b);
      r = hamilton(t, a_conj);
      res.w = '0;
      res.x = round_clamp(r.x, 2 * FRAC_W);
      res.y = round_clamp(r.y, 2 * FRAC_W);
      res.z = round_clamp(r.z, 2 * FRAC_W);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_op(kind_t k, int aw, int ax, int ay, int az,
                          int bw, int bx, int by, int bz);
    quat_op_t op;
    op.kind = k;
    op.a_w = comp_t'(aw);
    op.a_x = comp_t'(ax);
    op.a_y = comp_t'(ay);
    op.a_z = comp_t'(az);
    op.b_w = comp_t'(bw);
    op.b_x = comp_t'(bx);
    op.b_y = comp_t'(by);
    op.b_z = comp_t'(bz);
    quat_pend.push_back(op);
  endtask

  // Mix full-range values, moderate near-unit values and corner values.
  function automatic comp_t pick_comp();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return comp_t'($urandom);
    if (sel < 8) return comp_t'(int'($urandom_range(0, 16383)) - 8192);
    case ($urandom_range(0, 6))
      0: return comp_t'(-32768);
      1: return comp_t'(32767);
      2: return comp_t'(0);
      3: return comp_t'(-1);
      4: return comp_t'(1);
      5: return comp_t'(4096);
      default: return comp_t'(-4096);
    endcase
  endfunction

  task automatic queue_random(int count);
    quat_op_t op;
    for (int i = 0; i < count; i++) begin
      op.kind = $urandom_range(0, 1) ? KIND_ROTATE : KIND_PRODUCT;
      op.a_w = pick_comp();
      op.a_x = pick_comp();
      op.a_y = pick_comp();
      op.a_z = pick_comp();
      op.b_w = pick_comp();
      op.b_x = pick_comp();
      op.b_y = pick_comp();
      op.b_z = pick_comp();
      quat_pend.push_back(op);
    end
  endtask

  // Hold until every queued operation has transferred and every result is back.
  task automatic wait_drained();
    while (!(quat_pend.size() == 0 && in_valid == 1'b0 && quat_expect.size() == 0))
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer at the falling edge, hold until transferred.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    quat_op_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_xfer) begin
      // Slot is free: either start the next transfer or idle this cycle.
      if (quat_pend.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = quat_pend.pop_front();
        in_kind  <= nxt.kind;
        in_a_w   <= nxt.a_w;
        in_a_x   <= nxt.a_x;
        in_a_y   <= nxt.a_y;
        in_a_z   <= nxt.a_z;
        in_b_w   <= nxt.b_w;
        in_b_x   <= nxt.b_x;
        in_b_y   <= nxt.b_y;
        in_b_z   <= nxt.b_z;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    // Receiver: random backpressure, forced low during the long hold-off.
    out_ready <= rst_n && !holdoff_active && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Count the hold-off in cycles once it is armed.
  always @(negedge clk) begin
    if (holdoff_active) begin
      if (holdoff_cnt == HOLDOFF_CYCLES - 1) holdoff_done <= 1'b1;
      holdoff_cnt <= holdoff_cnt + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    quat_op_t  seen;
    quat_res_t got;
    quat_res_t want;
    in_xfer <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      // Predict the result of the operation just transferred.
      seen.kind = kind_t'(in_kind);
      seen.a_w = in_a_w;
      seen.a_x = in_a_x;
      seen.a_y = in_a_y;
      seen.a_z = in_a_z;
      seen.b_w = in_b_w;
      seen.b_x = in_b_x;
      seen.b_y = in_b_y;
      seen.b_z = in_b_z;
      quat_expect.push_back(quat_eval(seen));
    end
    if (rst_n && out_valid && out_ready) begin
      got.w = out_r_w;
      got.x = out_r_x;
      got.y = out_r_y;
      got.z = out_r_z;
      if (quat_expect.size() == 0) begin
        bad_count++;
        if (bad_count <= MAX_REPORTS)
          $display("[%0t] unexpected result #%0d: w=%0d x=%0d y=%0d z=%0d",
                   $time, result_count, got.w, got.x, got.y, got.z);
      end else begin
        want = quat_expect.pop_front();
        if (got.w !== want.w || got.x !== want.x || got.y !== want.y ||
            got.z !== want.z) begin
          bad_count++;
          if (bad_count <= MAX_REPORTS)
            $display("[%0t] result #%0d expected %0d %0d %0d %0d got %0d %0d %0d %0d",
                     $time, result_count, want.w, want.x, want.y, want.z,
                     got.w, got.x, got.y, got.z);
        end
      end
      result_count++;
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Phase 1: sender mostly busy, receiver mostly stalled.
    send_idle_pct = 8;
    recv_idle_pct = 87;

    // Directed products: zero, identity, basis product, saturation both ways,
    // and rounding ties on either sign.
    queue_op(KIND_PRODUCT, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_op(KIND_PRODUCT, 4096, 0, 0, 0, 1000, -2000, 3000, -4000);
    queue_op(KIND_PRODUCT, 0, 4096, 0, 0, 0, 0, 4096, 0);
    queue_op(KIND_PRODUCT, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    queue_op(KIND_PRODUCT, -32768, -32768, -32768, -32768,
             -32768, -32768, -32768, -32768);
    queue_op(KIND_PRODUCT, 32767, -32768, 32767, -32768,
             -32768, 32767, -32768, 32767);
    queue_op(KIND_PRODUCT, 1, 0, 0, 0, 2048, 0, 0, 0);
    queue_op(KIND_PRODUCT, -1, 0, 0, 0, 2048, 0, 0, 0);
    queue_op(KIND_PRODUCT, 1, 1, 1, 1, -2048, 2048, -2048, 2048);
    queue_op(KIND_PRODUCT, -1, -1, -1, -1, -1, -1, -1, -1);
    // Directed rotations: identity with b_w at both extremes (must not
    // matter), quarter and half turns, rounding ties, zero A and a huge A.
    queue_op(KIND_ROTATE, 4096, 0, 0, 0, -32768, 1234, -5678, 32767);
    queue_op(KIND_ROTATE, 4096, 0, 0, 0, 32767, 1234, -5678, 32767);
    queue_op(KIND_ROTATE, 2896, 0, 0, 2896, 0, 4096, 0, 0);
    queue_op(KIND_ROTATE, 0, 4096, 0, 0, 0, 0, 4096, -4096);
    queue_op(KIND_ROTATE, 64, 0, 0, 0, 0, 2048, -2048, 0);
    queue_op(KIND_ROTATE, -64, 0, 0, 0, 0, -2048, 2048, 1);
    queue_op(KIND_ROTATE, 0, 0, 0, 0, 32767, 32767, -32768, 32767);
    queue_op(KIND_ROTATE, -32768, -32768, -32768, -32768, 0, 32767, 32767, 32767);
    queue_op(KIND_ROTATE, 32767, 32767, 32767, 32767, -1, -32768, -32768, -32768);
    queue_op(KIND_ROTATE, -1, -1, -1, -1, -1, -1, -1, -1);
    queue_random(RAND_PER_PHASE);

    // Release reset at a falling edge; the driver holds off until reset is released.
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    wait_drained();

    // Phase 2: sender mostly idle, receiver mostly ready.
    send_idle_pct = 87;
    recv_idle_pct = 8;
    queue_random(RAND_PER_PHASE);
    wait_drained();

    // Phase 3: full rate both sides, opened by a long receiver hold-off so
    // the pipeline fills and pushes back on the input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(RAND_PER_PHASE);
    holdoff_go = 1'b1;
    wait_drained();

    // Let any stray result surface before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_count == 0 && quat_expect.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
